// File: hdl/epoch_seconds_to_calendar_macros.svh
// Assertion macros shared by the calendar converter RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ESC_CHECK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ESC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/esc_pkg.sv
// Constants, microcode types and control store of the epoch-to-calendar converter.
package esc_pkg;

  localparam int EPOCH_W = 40;
  localparam int REM_W   = 41;
  localparam int QUO_W   = 21;
  localparam int PC_W    = 4;
  localparam int CNT_W   = 5;

  localparam longint unsigned SEC_PER_DAY  = 86400;
  localparam longint unsigned SEC_PER_WEEK = 86400 * 7;
  localparam longint unsigned DAYS_PER_ERA = 146097;

  // Day bias: 40 whole eras plus the shift to the March-based era origin, so
  // that the biased day count is non-negative and counts from an era start.
  localparam int ERA_BIAS = 40;
  localparam longint unsigned BIAS_DAYS = ERA_BIAS * DAYS_PER_ERA + 719468;
  localparam logic [REM_W-1:0] BIAS_SEC = REM_W'(BIAS_DAYS * SEC_PER_DAY);

  // Weekday of the biased day count, moved so that the epoch day is Thursday.
  localparam logic [2:0] WDAY_ADJ = 3'((4 + 7 - (BIAS_DAYS % 7)) % 7);

  localparam int YEAR_BIAS    = ERA_BIAS * 400 + 1900;
  localparam int YEAR_OFF_MIN = -147;
  localparam int YEAR_OFF_MAX = 8099;

  typedef enum logic [2:0] {
    OP_DIV,
    OP_DAYS,
    OP_DOEADJ,
    OP_DOY,
    OP_SCALE,
    OP_DONE
  } uop_t;

  typedef enum logic [3:0] {
    Q_NONE,
    Q_WEEKS,
    Q_WDAY,
    Q_HOUR,
    Q_MIN,
    Q_ERA,
    Q_LEAPS,
    Q_YOE,
    Q_MP
  } qdst_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_SEC,
    R_DOE
  } rdst_t;

  typedef struct packed {
    uop_t             op;
    logic [REM_W-1:0] dsh;   // divisor pre-shifted to the top quotient bit
    logic [CNT_W-1:0] cnt;   // quotient bits minus one
    qdst_t            qdst;
    rdst_t            rdst;
  } ctrl_t;

  function automatic ctrl_t mk_div(input longint unsigned d, input int n,
                                    input qdst_t qd, input rdst_t rd);
    ctrl_t c;
    c.op   = OP_DIV;
    c.dsh  = REM_W'(d << (n - 1));
    c.cnt  = CNT_W'(n - 1);
    c.qdst = qd;
    c.rdst = rd;
    return c;
  endfunction

  function automatic ctrl_t mk_op(input uop_t op);
    ctrl_t c;
    c.op   = op;
    c.dsh  = '0;
    c.cnt  = '0;
    c.qdst = Q_NONE;
    c.rdst = R_NONE;
    return c;
  endfunction

  // Control store. Each division step loops on itself until its last
  // quotient bit, then writes its quotient and remainder where the word says.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      4'd0:    c = mk_div(SEC_PER_WEEK, 21, Q_WEEKS, R_NONE);
      4'd1:    c = mk_div(SEC_PER_DAY, 3, Q_WDAY, R_NONE);
      4'd2:    c = mk_div(3600, 5, Q_HOUR, R_NONE);
      4'd3:    c = mk_div(60, 6, Q_MIN, R_SEC);
      4'd4:    c = mk_op(OP_DAYS);
      4'd5:    c = mk_div(DAYS_PER_ERA, 7, Q_ERA, R_DOE);
      4'd6:    c = mk_div(1460, 7, Q_LEAPS, R_NONE);
      4'd7:    c = mk_op(OP_DOEADJ);
      4'd8:    c = mk_div(365, 9, Q_YOE, R_NONE);
      4'd9:    c = mk_op(OP_DOY);
      4'd10:   c = mk_op(OP_SCALE);
      4'd11:   c = mk_div(153, 4, Q_MP, R_NONE);
      default: c = mk_op(OP_DONE);
    endcase
    return c;
  endfunction

  // First day of each March-based month, counted from March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar.sv
// Epoch seconds to Gregorian calendar converter, microcoded over a shared divider.
//
// Usage: an epoch count (signed seconds since 1970-01-01 UTC) is taken on the
// in_ channel when in_valid is high and in_stall is low. The result leaves on
// the out_ channel when out_valid is high and out_stall is low.
// The converter handles one request at a time: in_stall stays high while the
// program runs. A short control store sequences one restoring divider that
// yields one quotient bit per cycle; the divisions need 62 bits in all, plus
// four arithmetic steps and a final step that writes the result. in_stall
// falls in the same cycle that out_valid rises, so a new request can be
// taken in that cycle.
// The result sits in an output register; a new request may be accepted while
// it waits. If out_stall still holds an earlier result when a program ends,
// the final step waits until that result is taken.
// Reset (rst_n low, synchronous) drops out_valid and returns the sequencer
// to its idle state; any request in flight is lost.
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [esc_pkg::EPOCH_W-1:0] in_epoch_seconds,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_out_of_range,
  output logic signed [13:0]                 out_year_offset,
  output logic [3:0]                         out_month_index,
  output logic [4:0]                         out_day_of_month,
  output logic [8:0]                         out_day_of_year,
  output logic [2:0]                         out_weekday,
  output logic [4:0]                         out_hour_of_day,
  output logic [5:0]                         out_minute_of_hour,
  output logic [5:0]                         out_second_of_minute
);
  import esc_pkg::*;

  // Sequencer and divider.
  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             first_r, first_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;

  // Intermediate results.
  logic [20:0] wk_r;
  logic [2:0]  dw_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [6:0]  era_r;
  logic [17:0] doe_r;
  logic [6:0]  leaps_r;
  logic [8:0]  yoe_r;
  logic [8:0]  doy_r;
  logic [3:0]  mp_r;

  // Output payload.
  logic        oor_r;
  logic [13:0] yoff_r;
  logic [3:0]  mon_r;
  logic [4:0]  dom_r;
  logic [8:0]  yday_r;
  logic [2:0]  wday_r;
  logic [4:0]  ohour_r;
  logic [5:0]  omin_r;
  logic [5:0]  osec_r;

  ctrl_t            cw;
  logic [REM_W-1:0] dsh_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [QUO_W-1:0] quo_eff;
  logic             div_ge;
  logic             div_last;
  logic [REM_W-1:0] div_rem;
  logic [QUO_W-1:0] div_quo;
  logic             q_we;
  logic             doy_we;
  logic             done_fire;

  logic [23:0]        days_val;
  logic [2:0]         cent_cnt;
  logic [17:0]        doe_adj;
  logic [1:0]         q100;
  logic [17:0]        doy_full;
  logic               janfeb;
  logic [3:0]         mon_val;
  logic [8:0]         dom_full;
  logic [16:0]        yr_sum;
  logic signed [16:0] yoff;
  logic               oor;
  logic               leap;
  logic [8:0]         yday_val;
  logic [3:0]         wsum;
  logic [2:0]         wday_val;

  assign cw = ucode(pc_r);

  // One restoring step per cycle; the first step of a division takes its
  // divisor and bit count from the control word.
  assign dsh_eff  = first_r ? cw.dsh : dsh_r;
  assign cnt_eff  = first_r ? cw.cnt : cnt_r;
  assign quo_eff  = first_r ? '0 : quo_r;
  assign div_ge   = rem_r >= dsh_eff;
  assign div_rem  = div_ge ? rem_r - dsh_eff : rem_r;
  assign div_quo  = {quo_eff[QUO_W-2:0], div_ge};
  assign div_last = cnt_eff == '0;

  // Biased day count from whole weeks and the day within the week.
  assign days_val = {wk_r, 3'b000} - {3'b000, wk_r} + 24'(dw_r);

  // Day of era with the four-year, century and era leap corrections.
  assign cent_cnt = 3'(doe_r >= 18'd36524) + 3'(doe_r >= 18'd73048)
                  + 3'(doe_r >= 18'd109572) + 3'(doe_r >= 18'd146096);
  assign doe_adj  = doe_r - 18'(leaps_r) + 18'(cent_cnt) - 18'(doe_r == 18'd146096);

  assign q100     = 2'(yoe_r >= 9'd100) + 2'(yoe_r >= 9'd200) + 2'(yoe_r >= 9'd300);
  assign doy_full = doe_r - (18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(q100));

  // Final assembly.
  assign janfeb   = mp_r >= 4'd10;
  assign mon_val  = janfeb ? mp_r - 4'd10 : mp_r + 4'd2;
  assign dom_full = doy_r - month_start(mp_r) + 9'd1;
  assign yr_sum   = 17'(era_r) * 17'd400 + 17'(yoe_r) + 17'(janfeb);
  assign yoff     = signed'(yr_sum - 17'(YEAR_BIAS));
  assign oor      = (yoff < YEAR_OFF_MIN) || (yoff > YEAR_OFF_MAX);
  // March to December lie in the Gregorian year numbered by yoe.
  assign leap     = (yoe_r[1:0] == 2'b00) && (yoe_r != 9'd100) && (yoe_r != 9'd200)
                  && (yoe_r != 9'd300);
  assign yday_val = janfeb ? doy_r - 9'd306 : doy_r + 9'd59 + 9'(leap);
  assign wsum     = 4'(dw_r) + 4'(WDAY_ADJ);
  assign wday_val = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    first_nxt = first_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    q_we      = 1'b0;
    doy_we    = 1'b0;
    done_fire = 1'b0;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt  = 1'b1;
        pc_nxt    = '0;
        first_nxt = 1'b1;
        rem_nxt   = REM_W'(in_epoch_seconds) + BIAS_SEC;
      end
    end else begin
      unique case (cw.op)
        OP_DIV: begin
          rem_nxt = div_rem;
          quo_nxt = div_quo;
          dsh_nxt = dsh_eff >> 1;
          if (div_last) begin
            q_we      = 1'b1;
            pc_nxt    = pc_r + 1'b1;
            first_nxt = 1'b1;
          end else begin
            cnt_nxt   = cnt_eff - 1'b1;
            first_nxt = 1'b0;
          end
        end
        OP_DAYS: begin
          rem_nxt = REM_W'(days_val);
          pc_nxt  = pc_r + 1'b1;
        end
        OP_DOEADJ: begin
          rem_nxt = REM_W'(doe_adj);
          pc_nxt  = pc_r + 1'b1;
        end
        OP_DOY: begin
          doy_we = 1'b1;
          pc_nxt = pc_r + 1'b1;
        end
        OP_SCALE: begin
          rem_nxt = REM_W'({doy_r, 2'b00}) + REM_W'(doy_r) + REM_W'(2);
          pc_nxt  = pc_r + 1'b1;
        end
        OP_DONE: begin
          if (!out_valid_r || !out_stall) begin
            done_fire = 1'b1;
            busy_nxt  = 1'b0;
            pc_nxt    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      first_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    if (q_we) begin
      unique case (cw.qdst)
        Q_NONE:  ;
        Q_WEEKS: wk_r    <= div_quo[20:0];
        Q_WDAY:  dw_r    <= div_quo[2:0];
        Q_HOUR:  hour_r  <= div_quo[4:0];
        Q_MIN:   min_r   <= div_quo[5:0];
        Q_ERA:   era_r   <= div_quo[6:0];
        Q_LEAPS: leaps_r <= div_quo[6:0];
        Q_YOE:   yoe_r   <= div_quo[8:0];
        Q_MP:    mp_r    <= div_quo[3:0];
        default: ;
      endcase
      unique case (cw.rdst)
        R_NONE:  ;
        R_SEC:   sec_r <= div_rem[5:0];
        R_DOE:   doe_r <= div_rem[17:0];
        default: ;
      endcase
    end
    if (doy_we) begin
      doy_r <= doy_full[8:0];
    end
    if (done_fire) begin
      oor_r   <= oor;
      yoff_r  <= oor ? '0 : yoff[13:0];
      mon_r   <= oor ? '0 : mon_val;
      dom_r   <= oor ? '0 : dom_full[4:0];
      yday_r  <= oor ? '0 : yday_val;
      wday_r  <= oor ? '0 : wday_val;
      ohour_r <= oor ? '0 : hour_r;
      omin_r  <= oor ? '0 : min_r;
      osec_r  <= oor ? '0 : sec_r;
    end
  end

  assign in_stall             = busy_r;
  assign out_valid            = out_valid_r;
  assign out_out_of_range     = oor_r;
  assign out_year_offset      = signed'(yoff_r);
  assign out_month_index      = mon_r;
  assign out_day_of_month     = dom_r;
  assign out_day_of_year      = yday_r;
  assign out_weekday          = wday_r;
  assign out_hour_of_day      = ohour_r;
  assign out_minute_of_hour   = omin_r;
  assign out_second_of_minute = osec_r;

  `ESC_CHECK_NEXT(a_accept_starts_program, in_valid && !in_stall, in_stall && pc_r == '0, "accepted request did not start the program")
  `ESC_CHECK_IMPL(a_div_quotient_fits, busy_r && cw.op == OP_DIV && first_r, {1'b0, rem_r} < {cw.dsh, 1'b0}, "dividend too large for quotient width")
  `ESC_CHECK_NEXT(a_result_from_program, !busy_r && !out_valid_r, !out_valid_r, "result appeared without a running program")
  `ESC_CHECK_IMPL(a_oor_fields_zero, out_valid && out_out_of_range, out_year_offset == '0 && out_day_of_month == '0 && out_weekday == '0 && out_hour_of_day == '0, "out-of-range result has nonzero fields")
  `ESC_CHECK_IMPL(a_fields_legal, out_valid && !out_out_of_range, out_month_index <= 4'd11 && out_day_of_month != '0 && out_weekday <= 3'd6 && out_hour_of_day <= 5'd23, "in-range result has an illegal field")

endmodule

// File: bench/epoch_calendar_checker.sv
// Checker for the epoch-to-calendar converter: predicts each date and compares results.
`timescale 1ns / 1ps

module epoch_calendar_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [esc_pkg::EPOCH_W-1:0] in_epoch_seconds,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               out_out_of_range,
  input  logic signed [13:0]                 out_year_offset,
  input  logic [3:0]                         out_month_index,
  input  logic [4:0]                         out_day_of_month,
  input  logic [8:0]                         out_day_of_year,
  input  logic [2:0]                         out_weekday,
  input  logic [4:0]                         out_hour_of_day,
  input  logic [5:0]                         out_minute_of_hour,
  input  logic [5:0]                         out_second_of_minute,
  output int                                 errors,
  output int                                 pending,
  output int                                 checked,
  output int                                 out_of_range_seen,
  output int                                 pre_epoch_seen
);

  localparam longint DAY_SECS      = 86400;
  localparam longint ERA_DAYS      = 146097;
  localparam longint MARCH_SHIFT   = 719468;
  localparam int     REPORT_LINES  = 40;

  typedef struct packed {
    logic               out_of_range;
    logic signed [13:0] year_offset;
    logic [3:0]         month_index;
    logic [4:0]         day_of_month;
    logic [8:0]         day_of_year;
    logic [2:0]         weekday;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [5:0]         second_of_minute;
  } calendar_t;

  calendar_t expected_dates[$];
  longint    request_secs[$];

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if (a % b < 0) q--;
    return q;
  endfunction

  function automatic longint floor_mod(input longint a, input longint b);
    longint r;
    r = a % b;
    if (r < 0) r += b;
    return r;
  endfunction

  // Days are counted in 400-year eras that begin on March 1, so the leap day
  // always falls at the end of the shifted year.
  function automatic calendar_t calendar_of(input logic signed [esc_pkg::EPOCH_W-1:0] secs);
    longint    t, days, sod, z, era, doe, yoe, doy, mp, d, m, y, yday;
    logic      leap;
    calendar_t r;
    t    = longint'(secs);
    days = floor_div(t, DAY_SECS);
    sod  = floor_mod(t, DAY_SECS);
    z    = days + MARCH_SHIFT;
    era  = floor_div(z, ERA_DAYS);
    doe  = z - era * ERA_DAYS;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y    = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 2 : mp - 10;
    if (m <= 1) y++;
    r = '0;
    if (y - 1900 < esc_pkg::YEAR_OFF_MIN || y - 1900 > esc_pkg::YEAR_OFF_MAX) begin
      r.out_of_range = 1'b1;
      return r;
    end
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    // January and February close the shifted year; March opens it after 59 days, or 60 in a leap year.
    if (m <= 1) yday = doy - 306;
    else yday = doy + 59 + (leap ? 1 : 0);
    r.year_offset      = 14'(y - 1900);
    r.month_index      = 4'(m);
    r.day_of_month     = 5'(d);
    r.day_of_year      = 9'(yday);
    r.weekday          = 3'(floor_mod(days + 4, 7));
    r.hour_of_day      = 5'(sod / 3600);
    r.minute_of_hour   = 6'((sod / 60) % 60);
    r.second_of_minute = 6'(sod % 60);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < REPORT_LINES) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint secs,
                             input logic signed [14:0] got, input logic signed [14:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s for epoch %0d: got %0d, expected %0d",
                                name, secs, got, want));
  endtask

  always @(posedge clk) begin
    calendar_t want;
    longint    secs;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_dates.push_back(calendar_of(in_epoch_seconds));
        request_secs.push_back(longint'(in_epoch_seconds));
        if (in_epoch_seconds < 0) pre_epoch_seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, year offset %0d",
                                    out_year_offset));
        end else begin
          want = expected_dates.pop_front();
          secs = request_secs.pop_front();
          check_field("out_of_range", secs, out_out_of_range, want.out_of_range);
          check_field("year_offset", secs, out_year_offset, want.year_offset);
          check_field("month_index", secs, out_month_index, want.month_index);
          check_field("day_of_month", secs, out_day_of_month, want.day_of_month);
          check_field("day_of_year", secs, out_day_of_year, want.day_of_year);
          check_field("weekday", secs, out_weekday, want.weekday);
          check_field("hour_of_day", secs, out_hour_of_day, want.hour_of_day);
          check_field("minute_of_hour", secs, out_minute_of_hour, want.minute_of_hour);
          check_field("second_of_minute", secs, out_second_of_minute, want.second_of_minute);
          checked++;
          if (want.out_of_range) out_of_range_seen++;
        end
      end
    end
    pending <= expected_dates.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the calendar converter bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int          RANDOM_ITEMS = 1300;
  localparam int          CALM_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 900000;
  localparam int          DRAIN_CYCLES = 80;

  // Second counts at the edges of the reported years and the span between them.
  localparam longint FIRST_1753_SEC = -64'sd6847804800;
  localparam longint FIRST_10000_SEC = 64'sd253402300800;
  localparam longint unsigned IN_RANGE_SPAN = 64'd260250105600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [esc_pkg::EPOCH_W-1:0] in_epoch_seconds = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic out_out_of_range;
  logic signed [13:0] out_year_offset;
  logic [3:0] out_month_index;
  logic [4:0] out_day_of_month;
  logic [8:0] out_day_of_year;
  logic [2:0] out_weekday;
  logic [4:0] out_hour_of_day;
  logic [5:0] out_minute_of_hour;
  logic [5:0] out_second_of_minute;

  int errors, pending, checked, out_of_range_seen, pre_epoch_seen;
  int unsigned cycles = 0;
  int stall_mode = 1;
  int send_idle_pct = 25;

  always #1 clk = ~clk;

  epoch_seconds_to_calendar dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_out_of_range     (out_out_of_range),
    .out_year_offset      (out_year_offset),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_year      (out_day_of_year),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  epoch_calendar_checker date_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_out_of_range     (out_out_of_range),
    .out_year_offset      (out_year_offset),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_year      (out_day_of_year),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .errors               (errors),
    .pending              (pending),
    .checked              (checked),
    .out_of_range_seen    (out_of_range_seen),
    .pre_epoch_seen       (pre_epoch_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Half of the random counts land inside the reported years; the rest cover all 40
  // bits, the neighborhoods of calendar anchors and the 32-bit range.
  function automatic logic [esc_pkg::EPOCH_W-1:0] pick_epoch();
    longint unsigned r;
    longint          base, v;
    int              kind;
    kind = $urandom_range(0, 99);
    r = {$urandom, $urandom};
    if (kind < 50) begin
      v = FIRST_1753_SEC + longint'(r % IN_RANGE_SPAN);
    end else if (kind < 65) begin
      v = longint'(r);
    end else if (kind < 85) begin
      case ($urandom_range(0, 7))
        0:       base = FIRST_1753_SEC;
        1:       base = FIRST_10000_SEC;
        2:       base = 0;
        3:       base = 64'sd951868800;
        4:       base = -64'sd2203891200;
        5:       base = 64'sd4107542400;
        6:       base = -64'sd58060800;
        default: base = 64'sd978307200;
      endcase
      v = base + (longint'($urandom_range(0, 400000)) - 200000) *
                 ($urandom_range(0, 1) ? 1 : 43);
    end else begin
      v = longint'(int'($urandom));
    end
    return v[esc_pkg::EPOCH_W-1:0];
  endfunction

  task automatic pause_sender();
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Holds the request until the edge at which the converter takes it.
  task automatic send_epoch(input logic [esc_pkg::EPOCH_W-1:0] secs);
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : receiver
    forever begin
      if (stall_mode == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 9) < (stall_mode == 2 ? 8 : 3)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, stall_mode == 2 ? 3 : 30)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    longint corner [22];
    int     i;
    corner = '{0, -1, 86399, 86400, -86400, -86401,
               64'sd549755813887, -64'sd549755813888,
               FIRST_1753_SEC, FIRST_1753_SEC - 1,
               FIRST_10000_SEC - 1, FIRST_10000_SEC,
               64'sd951782400, 64'sd951868800, 64'sd978220800,
               -64'sd2203891200, -64'sd2203891201, -64'sd58060800,
               64'sd4107542399, 64'sd2147483648, -64'sd2147483649, 64'sd1234567890};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner[i]) begin
      pause_sender();
      send_epoch(corner[i][esc_pkg::EPOCH_W-1:0]);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        stall_mode = 0;
        send_idle_pct = 0;
      end else if (i % 100 == 0) begin
        stall_mode = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0:       send_idle_pct = 0;
          1:       send_idle_pct = 25;
          default: send_idle_pct = 60;
        endcase
      end
      // Midway the sender holds off until every request has been answered.
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      pause_sender();
      send_epoch(pick_epoch());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d conversions: %0d outside years 1753 to 9999, %0d before 1970.",
             checked, out_of_range_seen, pre_epoch_seen);
    $display("Requests ran with random sender gaps and result stalls, then without either.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/esc_pkg.sv
hdl/epoch_seconds_to_calendar.sv
bench/epoch_calendar_checker.sv
bench/testbench.sv
